@@ sv/dqs_pkg.sv @@
package dqs_pkg;

    localparam int DEPTH = 16;
    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = IDX_W + 1;

    localparam logic [2:0] ACT_PUSH_FRONT = 3'd0;
    localparam logic [2:0] ACT_PUSH_BACK  = 3'd1;
    localparam logic [2:0] ACT_POP_FRONT  = 3'd2;
    localparam logic [2:0] ACT_POP_BACK   = 3'd3;
    localparam logic [2:0] ACT_SEARCH     = 3'd4;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_FULL      = 2'd1;
    localparam logic [1:0] ST_EMPTY     = 2'd2;
    localparam logic [1:0] ST_NOT_FOUND = 2'd3;

    typedef struct packed {
        logic [2:0]         action;
        logic signed [31:0] data_value;
    } cmd_t;

    typedef struct packed {
        logic [1:0]         status;
        logic [3:0]         found_position;
        logic signed [31:0] removed_value;
    } res_t;

    typedef struct packed {
        logic               wr_en;
        logic [IDX_W-1:0]   wr_addr;
        logic signed [31:0] wr_data;
        logic               rd_en;
        logic [IDX_W-1:0]   rd_addr;
    } store_req_t;

    // Slot that lies off entries behind base in the circular store.
    // The caller keeps off below DEPTH, so one conditional subtract wraps it.
    function automatic logic [IDX_W-1:0] slot_add(input logic [IDX_W-1:0] base,
                                                  input logic [CNT_W-1:0] off);
        logic [CNT_W:0] sum;
        sum = (CNT_W+1)'(base) + (CNT_W+1)'(off);
        if (sum >= (CNT_W+1)'(DEPTH))
        begin
            sum = sum - (CNT_W+1)'(DEPTH);
        end
        return sum[IDX_W-1:0];
    endfunction

endpackage

@@ sv/dqs_store.sv @@
module dqs_store
    import dqs_pkg::*;
(
    input  logic               clk,
    input  store_req_t         req,
    output logic signed [31:0] rd_data
);

    logic signed [31:0] mem [DEPTH];
    logic signed [31:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.wr_addr] <= req.wr_data;
        end
        if (req.rd_en)
        begin
            rd_data_reg <= mem[req.rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ sv/deque_with_search.sv @@
// Channel   Direction  Transfer when        Payload
// command   in         start && !busy      cmd    (action, data_value)
// result    out        done                result (status, found_position, removed_value)
//
// Pushes, unused action codes and every refused action show their result in the
// cycle after the transfer and leave busy low, so a new command may follow at once.
// A pop passes through S_POP for the registered read of the entry store.
// A search reads one entry per cycle through the single read port and one
// comparator, from the front, and stops at the first match or the last entry.
// Reset clears the state, done, the front pointer and the count only; the store needs no clearing.
// The receiver cannot stall: done is high for one cycle per command.
module deque_with_search
    import dqs_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    input  cmd_t cmd,
    output logic busy,
    output logic done,
    output res_t result
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_POP  = 3'b010,
        S_SCAN = 3'b100
    } state_t;

    state_t             state_reg, state_next;
    logic [IDX_W-1:0]   front_reg, front_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [IDX_W-1:0]   pos_reg, pos_next;
    logic [IDX_W-1:0]   scan_addr_reg, scan_addr_next;
    logic signed [31:0] value_reg, value_next;
    logic               done_reg, done_next;
    res_t               result_reg, result_next;
    store_req_t         req;
    logic signed [31:0] rd_data;
    logic               is_full;
    logic               is_empty;

    dqs_store u_store (
        .clk     (clk),
        .req     (req),
        .rd_data (rd_data)
    );

    assign is_full  = (count_reg == CNT_W'(DEPTH));
    assign is_empty = (count_reg == '0);

    always_comb
    begin
        state_next     = state_reg;
        front_next     = front_reg;
        count_next     = count_reg;
        pos_next       = pos_reg;
        scan_addr_next = scan_addr_reg;
        value_next     = value_reg;
        done_next      = 1'b0;
        result_next    = result_reg;
        req            = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    value_next  = cmd.data_value;
                    done_next   = 1'b1;
                    result_next = '{status: ST_OK, found_position: '0, removed_value: '0};
                    case (cmd.action)
                        ACT_PUSH_FRONT:
                        begin
                            if (is_full)
                            begin
                                result_next.status = ST_FULL;
                            end
                            else
                            begin
                                front_next  = slot_add(front_reg, CNT_W'(DEPTH - 1));
                                req.wr_en   = 1'b1;
                                req.wr_addr = front_next;
                                req.wr_data = cmd.data_value;
                                count_next  = count_reg + 1'b1;
                            end
                        end
                        ACT_PUSH_BACK:
                        begin
                            if (is_full)
                            begin
                                result_next.status = ST_FULL;
                            end
                            else
                            begin
                                req.wr_en   = 1'b1;
                                req.wr_addr = slot_add(front_reg, count_reg);
                                req.wr_data = cmd.data_value;
                                count_next  = count_reg + 1'b1;
                            end
                        end
                        ACT_POP_FRONT:
                        begin
                            if (is_empty)
                            begin
                                result_next.status = ST_EMPTY;
                            end
                            else
                            begin
                                req.rd_en   = 1'b1;
                                req.rd_addr = front_reg;
                                front_next  = slot_add(front_reg, CNT_W'(1));
                                count_next  = count_reg - 1'b1;
                                done_next   = 1'b0;
                                state_next  = S_POP;
                            end
                        end
                        ACT_POP_BACK:
                        begin
                            if (is_empty)
                            begin
                                result_next.status = ST_EMPTY;
                            end
                            else
                            begin
                                req.rd_en   = 1'b1;
                                req.rd_addr = slot_add(front_reg, count_reg - 1'b1);
                                count_next  = count_reg - 1'b1;
                                done_next   = 1'b0;
                                state_next  = S_POP;
                            end
                        end
                        ACT_SEARCH:
                        begin
                            if (is_empty)
                            begin
                                result_next.status = ST_NOT_FOUND;
                            end
                            else
                            begin
                                req.rd_en      = 1'b1;
                                req.rd_addr    = front_reg;
                                scan_addr_next = front_reg;
                                pos_next       = '0;
                                done_next      = 1'b0;
                                state_next     = S_SCAN;
                            end
                        end
                        default:
                        begin
                            // Unused action codes give a plain ok result.
                        end
                    endcase
                end
            end
            S_POP:
            begin
                done_next   = 1'b1;
                result_next = '{status: ST_OK, found_position: '0, removed_value: rd_data};
                state_next  = S_IDLE;
            end
            S_SCAN:
            begin
                // rd_data holds the entry at position pos_reg from the front.
                if (rd_data == value_reg)
                begin
                    done_next   = 1'b1;
                    result_next = '{status: ST_OK, found_position: 4'(pos_reg),
                                    removed_value: '0};
                    state_next  = S_IDLE;
                end
                else if ((CNT_W'(pos_reg) + 1'b1) == count_reg)
                begin
                    done_next   = 1'b1;
                    result_next = '{status: ST_NOT_FOUND, found_position: '0,
                                    removed_value: '0};
                    state_next  = S_IDLE;
                end
                else
                begin
                    pos_next       = pos_reg + 1'b1;
                    scan_addr_next = slot_add(scan_addr_reg, CNT_W'(1));
                    req.rd_en      = 1'b1;
                    req.rd_addr    = scan_addr_next;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            front_reg <= '0;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            front_reg <= front_next;
            count_reg <= count_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg       <= pos_next;
        scan_addr_reg <= scan_addr_next;
        value_reg     <= value_next;
        result_reg    <= result_next;
    end

    assign busy   = (state_reg != S_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

endmodule

@@ test/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
    import dqs_pkg::*;

    // Action codes that the block answers with a plain ok result and no other effect.
    localparam logic [2:0] ACT_SPARE_LO = 3'd5;
    localparam logic [2:0] ACT_SPARE_MID = 3'd6;
    localparam logic [2:0] ACT_SPARE_HI = 3'd7;

    localparam int ITEMS_PER_PHASE = 250;
    localparam int STALL_LIMIT = 1000;
    localparam int SETTLE_CYCLES = DEPTH + 4;

    localparam res_t NO_RES = '0;
    localparam res_t RES_OK = '{ST_OK, 4'd0, 32'sd0};
    localparam res_t RES_FULL = '{ST_FULL, 4'd0, 32'sd0};
    localparam res_t RES_EMPTY = '{ST_EMPTY, 4'd0, 32'sd0};
    localparam res_t RES_MISS = '{ST_NOT_FOUND, 4'd0, 32'sd0};

    // One row of the directed plan: the command is sent reps times, with the
    // value counting up when step is set. A fixed row carries its result.
    typedef struct packed {
        cmd_t       c;
        logic [4:0] reps;
        logic       step;
        logic       fixed;
        res_t       want;
    } row_t;

    localparam int PLAN_ROWS = 23;
    localparam row_t PLAN [PLAN_ROWS] = '{
        '{'{ACT_POP_FRONT, 32'sd0}, 5'd1, 1'b0, 1'b1, RES_EMPTY},
        '{'{ACT_POP_BACK, -32'sd1}, 5'd1, 1'b0, 1'b1, RES_EMPTY},
        '{'{ACT_SEARCH, 32'sd0}, 5'd1, 1'b0, 1'b1, RES_MISS},
        '{'{ACT_SPARE_LO, -32'sd1}, 5'd1, 1'b0, 1'b1, RES_OK},
        '{'{ACT_SPARE_MID, 32'sh7FFFFFFF}, 5'd1, 1'b0, 1'b1, RES_OK},
        '{'{ACT_SPARE_HI, 32'sh5A5A5A5A}, 5'd1, 1'b0, 1'b1, RES_OK},
        '{'{ACT_PUSH_FRONT, 32'sh7FFFFFFF}, 5'd1, 1'b0, 1'b1, RES_OK},
        '{'{ACT_PUSH_BACK, 32'sh80000000}, 5'd1, 1'b0, 1'b1, RES_OK},
        '{'{ACT_PUSH_FRONT, -32'sd1}, 5'd1, 1'b0, 1'b1, RES_OK},
        '{'{ACT_SEARCH, 32'sh80000000}, 5'd1, 1'b0, 1'b0, NO_RES},
        '{'{ACT_SEARCH, 32'sd12345}, 5'd1, 1'b0, 1'b0, NO_RES},
        '{'{ACT_POP_BACK, 32'sd0}, 5'd1, 1'b0, 1'b0, NO_RES},
        '{'{ACT_POP_FRONT, 32'sd0}, 5'd1, 1'b0, 1'b0, NO_RES},
        '{'{ACT_PUSH_BACK, 32'sd5}, 5'd3, 1'b0, 1'b0, NO_RES},
        '{'{ACT_SEARCH, 32'sd5}, 5'd1, 1'b0, 1'b0, NO_RES},
        '{'{ACT_PUSH_BACK, 32'sd100}, 5'd12, 1'b1, 1'b0, NO_RES},
        '{'{ACT_PUSH_FRONT, 32'sd1}, 5'd1, 1'b0, 1'b1, RES_FULL},
        '{'{ACT_PUSH_BACK, 32'sd2}, 5'd1, 1'b0, 1'b1, RES_FULL},
        '{'{ACT_SEARCH, 32'sd111}, 5'd1, 1'b0, 1'b0, NO_RES},
        '{'{ACT_POP_FRONT, 32'sd0}, 5'd9, 1'b0, 1'b0, NO_RES},
        '{'{ACT_POP_BACK, 32'sd0}, 5'd7, 1'b0, 1'b0, NO_RES},
        '{'{ACT_POP_BACK, 32'sd0}, 5'd1, 1'b0, 1'b1, RES_EMPTY},
        '{'{ACT_SEARCH, 32'sh7FFFFFFF}, 5'd1, 1'b0, 1'b1, RES_MISS}
    };

    logic clk;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    cmd_t cmd = '0;
    logic busy;
    logic done;
    res_t result;

    // Carried along with each command so that fixed rows are checked against their own result, not the prediction.
    logic fixed_row = 1'b0;
    res_t fixed_res = '0;

    // Mirror of the deque contents.
    logic signed [31:0] held_value [DEPTH];
    int held_front = 0;
    int held_count = 0;

    res_t pending_results [$];
    logic signed [31:0] recent_pushes [$];
    int mismatches = 0;
    int quiet_cycles = 0;

    deque_with_search uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .cmd    (cmd),
        .busy   (busy),
        .done   (done),
        .result (result)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic int held_slot(input int offset);
        return (held_front + offset) % DEPTH;
    endfunction

    function automatic res_t deque_predict(input cmd_t c);
        res_t r;
        r = '0;
        case (c.action)
            ACT_PUSH_FRONT:
            begin
                if (held_count >= DEPTH)
                begin
                    r.status = ST_FULL;
                end
                else
                begin
                    held_front = (held_front == 0) ? DEPTH - 1 : held_front - 1;
                    held_value[held_front] = c.data_value;
                    held_count++;
                end
            end
            ACT_PUSH_BACK:
            begin
                if (held_count >= DEPTH)
                begin
                    r.status = ST_FULL;
                end
                else
                begin
                    held_value[held_slot(held_count)] = c.data_value;
                    held_count++;
                end
            end
            ACT_POP_FRONT:
            begin
                if (held_count == 0)
                begin
                    r.status = ST_EMPTY;
                end
                else
                begin
                    r.removed_value = held_value[held_front];
                    held_front = held_slot(1);
                    held_count--;
                end
            end
            ACT_POP_BACK:
            begin
                if (held_count == 0)
                begin
                    r.status = ST_EMPTY;
                end
                else
                begin
                    r.removed_value = held_value[held_slot(held_count - 1)];
                    held_count--;
                end
            end
            ACT_SEARCH:
            begin
                r.status = ST_NOT_FOUND;
                for (int i = 0; i < held_count; i++)
                begin
                    if (held_value[held_slot(i)] == c.data_value)
                    begin
                        r.status = ST_OK;
                        r.found_position = 4'(i);
                        break;
                    end
                end
            end
            default:
            begin
            end
        endcase
        return r;
    endfunction

    // Results are checked before the transfer of this edge is predicted, so the
    // order of the two never depends on the scheduler.
    always @(posedge clk)
    begin
        res_t want;
        if (rst_n && done)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t: result with no transfer pending: status %0d position %0d value %0d",
                         $time, result.status, result.found_position, result.removed_value);
                mismatches++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (result.status !== want.status)
                begin
                    $display("%0t: status expected %0d, got %0d",
                             $time, want.status, result.status);
                    mismatches++;
                end
                if (result.found_position !== want.found_position)
                begin
                    $display("%0t: found_position expected %0d, got %0d",
                             $time, want.found_position, result.found_position);
                    mismatches++;
                end
                if (result.removed_value !== want.removed_value)
                begin
                    $display("%0t: removed_value expected %0d, got %0d",
                             $time, want.removed_value, result.removed_value);
                    mismatches++;
                end
            end
        end
        if (rst_n && start && busy === 1'b0)
        begin
            want = deque_predict(cmd);
            pending_results.push_back(fixed_row ? fixed_res : want);
        end
        if (rst_n && ((start && busy === 1'b0) || done))
        begin
            quiet_cycles = 0;
        end
        else if (rst_n)
        begin
            quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    // Holds the command until the block takes it.
    task automatic issue(input cmd_t c, input logic fixed, input res_t want);
        start <= 1'b1;
        cmd <= c;
        fixed_row <= fixed;
        fixed_res <= want;
        do
            @(posedge clk);
        while (busy !== 1'b0);
    endtask

    task automatic idle_gap(input int pct);
        while ($urandom_range(99) < pct)
        begin
            start <= 1'b0;
            cmd <= cmd_t'({$urandom, $urandom});
            @(posedge clk);
        end
    endtask

    task automatic wait_all_results();
        start <= 1'b0;
        do
            @(posedge clk);
        while (pending_results.size() != 0 || busy !== 1'b0);
    endtask

    function automatic logic signed [31:0] random_value();
        case ($urandom_range(9))
            0: return 32'sh7FFFFFFF;
            1: return 32'sh80000000;
            2: return $urandom_range(1) ? -32'sd1 : 32'sd0;
            3, 4, 5: return 32'($urandom_range(7));
            default: return $urandom;
        endcase
    endfunction

    initial
    begin
        cmd_t c;
        int idle_pct [4];
        int push_pct [3];
        int bias;
        int burst_left;
        int roll;
        int sent;
        logic push;
        logic front;
        idle_pct = '{0, 53, 0, 38};
        push_pct = '{75, 25, 50};
        bias = 2;
        burst_left = 0;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < PLAN_ROWS; i++)
        begin
            for (int k = 0; k < PLAN[i].reps; k++)
            begin
                c = PLAN[i].c;
                if (PLAN[i].step)
                begin
                    c.data_value = c.data_value + k;
                end
                issue(c, PLAN[i].fixed, PLAN[i].want);
            end
        end
        wait_all_results();

        for (int phase = 0; phase < 4; phase++)
        begin
            sent = 0;
            while (sent < ITEMS_PER_PHASE)
            begin
                // Bursts lean toward filling, draining or neither, so that both
                // the full and the empty deque come up often.
                if (burst_left == 0)
                begin
                    bias = $urandom_range(2);
                    burst_left = $urandom_range(10, 40);
                end
                burst_left--;
                roll = $urandom_range(99);
                if (roll < 4)
                begin
                    c.action = 3'($urandom_range(ACT_SPARE_LO, ACT_SPARE_HI));
                    c.data_value = random_value();
                end
                else if (roll < 24)
                begin
                    c.action = ACT_SEARCH;
                    if (recent_pushes.size() != 0 && $urandom_range(99) < 60)
                    begin
                        c.data_value = recent_pushes[$urandom_range(recent_pushes.size() - 1)];
                    end
                    else
                    begin
                        c.data_value = random_value();
                    end
                end
                else
                begin
                    push = ($urandom_range(99) < push_pct[bias]);
                    front = $urandom_range(1);
                    if (push)
                    begin
                        c.action = front ? ACT_PUSH_FRONT : ACT_PUSH_BACK;
                    end
                    else
                    begin
                        c.action = front ? ACT_POP_FRONT : ACT_POP_BACK;
                    end
                    c.data_value = random_value();
                    if (push)
                    begin
                        recent_pushes.push_back(c.data_value);
                        if (recent_pushes.size() > DEPTH)
                        begin
                            recent_pushes.pop_front();
                        end
                    end
                end
                idle_gap(idle_pct[phase]);
                issue(c, 1'b0, NO_RES);
                if (c.action <= ACT_SEARCH)
                begin
                    sent++;
                end
            end
            wait_all_results();
        end

        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatches == 0)
        begin
            $display("CHECK OK");
        end
        else
        begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

@@ files.f @@
sv/dqs_pkg.sv
sv/dqs_store.sv
sv/deque_with_search.sv
test/testbench.sv
